// File: hdl/ple_pkg.sv
// ============================================================================
// ple_pkg - shared types and constants for the positional list engine
// Word store geometry, operation and status codes, and the packed transfer
// types of the input and result channels.
// ============================================================================
package ple_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef logic [3:0] t_op;
    localparam t_op OP_PUSH         = 4'd0;
    localparam t_op OP_POP          = 4'd1;
    localparam t_op OP_SET          = 4'd2;
    localparam t_op OP_GET          = 4'd3;
    localparam t_op OP_REMOVE       = 4'd4;
    localparam t_op OP_INSERT_FRONT = 4'd5;
    localparam t_op OP_REMOVE_FRONT = 4'd6;
    localparam t_op OP_SWAP         = 4'd7;
    localparam t_op OP_CLEAR        = 4'd8;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;
    localparam t_status ST_EMPTY = 2'd3;

    typedef struct packed {
        t_op         op;
        logic [5:0]  index;
        logic [5:0]  second_index;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_value;
        t_status     status;
        logic [6:0]  count;
    } t_out_item;

endpackage

// File: hdl/positional_list_engine.sv
// ============================================================================
// positional_list_engine - bounded list of words with positional operations
// A word store with one write and one registered read port, run by a small
// sequencer that performs push, pop, set, get, remove, insert-front,
// remove-front, swap and clear, one operation at a time.
// ============================================================================
//
//  channel   direction  handshake                     payload
//  --------  ---------  ----------------------------  ------------------------
//  input     in         i_in_valid  / o_in_ready      i_in_data  (t_in_item)
//  result    out        o_out_valid / i_out_ready     o_out_data (t_out_item)
//
//  Each operation: one transfer in, exactly one result transfer out.
//  Every entry moved by remove, remove-front or insert-front takes a
//  registered read, then a write, as the word store has a single read port.
//  Reset: synchronous, active low; length and all entry valid bits clear
//  together, an entry never written reads as empty.
//  Stalls: the result register holds a finished transfer while the next
//  operation is accepted and worked; only the hand-over of a new result waits.
//
module positional_list_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ple_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ple_pkg::t_out_item  o_out_data
);
    import ple_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,  // wait for an operation
        S_DISP = 9'b000000010,  // range checks, first access
        S_CHK  = 9'b000000100,  // act on the first read word
        S_NXT  = 9'b000001000,  // remove: look at the following slot
        S_SWB  = 9'b000010000,  // swap: second word arrived
        S_SWW  = 9'b000100000,  // swap: second write
        S_MRD  = 9'b001000000,  // move loop: issue read
        S_MWR  = 9'b010000000,  // move loop: write moved word
        S_DONE = 9'b100000000   // hand result to the output register
    } t_state;

    // Word store: array plus per-entry valid bits, so reset empties it at once.
    t_word              mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_word              r_rd_q;
    logic               r_rdv_q;

    t_state             r_state, n_state;
    t_op                r_op;
    logic [5:0]         r_ia, r_ib;
    t_word              r_val;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic               r_up, n_up;
    logic               r_oob, n_oob;
    t_word              r_a, n_a;
    t_word              r_res, n_res;
    t_status            r_st, n_st;
    logic               r_out_vld, n_out_vld;
    t_out_item          r_out, n_out;

    logic               w_en;
    logic [ADDR_W-1:0]  w_addr;
    t_word              w_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic               clr;
    t_word              rd_word;
    logic               in_xfer;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Entries never written since reset or clear read as empty.
    assign rd_word = r_rdv_q ? r_rd_q : '0;

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_k       = r_k;
        n_hi      = r_hi;
        n_up      = r_up;
        n_oob     = r_oob;
        n_a       = r_a;
        n_res     = r_res;
        n_st      = r_st;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        w_en      = 1'b0;
        w_addr    = '0;
        w_data    = '0;
        rd_addr   = '0;
        clr       = 1'b0;

        // Drop the result once it has been taken.
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res   = '0;
                    n_st    = ST_DONE;
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                n_state = S_DONE;
                case (r_op)
                    OP_PUSH: begin
                        if (32'(r_len) >= DEPTH) begin
                            n_st = ST_FULL;
                        end else begin
                            w_en   = 1'b1;
                            w_addr = ADDR_W'(r_len);
                            w_data = r_val;
                            n_len  = r_len + CNT_W'(1);
                        end
                    end
                    OP_POP: begin
                        if (r_len == '0) begin
                            n_st = ST_RANGE;
                        end else begin
                            rd_addr = ADDR_W'(r_len - CNT_W'(1));
                            n_state = S_CHK;
                        end
                    end
                    OP_SET: begin
                        if (32'(r_ia) >= DEPTH) begin
                            n_st = ST_RANGE;
                        end else begin
                            w_en   = 1'b1;
                            w_addr = ADDR_W'(r_ia);
                            w_data = r_val;
                            if (32'(r_ia) >= 32'(r_len)) begin
                                n_len = CNT_W'(32'(r_ia) + 32'd1);
                            end
                        end
                    end
                    OP_GET, OP_REMOVE: begin
                        if (32'(r_ia) >= 32'(r_len)) begin
                            n_st = ST_RANGE;
                        end else begin
                            rd_addr = ADDR_W'(r_ia);
                            n_state = S_CHK;
                        end
                    end
                    OP_INSERT_FRONT: begin
                        if (32'(r_len) >= DEPTH) begin
                            n_st = ST_FULL;
                        end else begin
                            n_k     = r_len;
                            n_up    = 1'b1;
                            n_state = S_MRD;
                        end
                    end
                    OP_REMOVE_FRONT: begin
                        if (r_len == '0) begin
                            n_st = ST_RANGE;
                        end else begin
                            rd_addr = '0;
                            n_state = S_CHK;
                        end
                    end
                    OP_SWAP: begin
                        if (r_ia == r_ib) begin
                            n_st = ST_DONE;
                        end else if (32'(r_ia) >= 32'(r_len) || 32'(r_ib) >= 32'(r_len)) begin
                            n_st = ST_RANGE;
                        end else begin
                            rd_addr = ADDR_W'(r_ia);
                            n_state = S_CHK;
                        end
                    end
                    OP_CLEAR: begin
                        clr   = 1'b1;
                        n_len = '0;
                    end
                    default: begin
                        n_st = ST_DONE;
                    end
                endcase
            end

            S_CHK: begin
                n_state = S_DONE;
                case (r_op)
                    OP_POP: begin
                        if (rd_word == '0) begin
                            n_st = ST_EMPTY;
                        end else begin
                            n_res  = rd_word;
                            w_en   = 1'b1;
                            w_addr = ADDR_W'(r_len - CNT_W'(1));
                            n_len  = r_len - CNT_W'(1);
                        end
                    end
                    OP_GET: begin
                        n_res = rd_word;
                        if (rd_word == '0) begin
                            n_st = ST_EMPTY;
                        end
                    end
                    OP_REMOVE: begin
                        if (rd_word == '0) begin
                            n_st = ST_EMPTY;
                        end else begin
                            n_res  = rd_word;
                            w_en   = 1'b1;
                            w_addr = ADDR_W'(r_ia);
                            n_len  = r_len - CNT_W'(1);
                            // Slot past the end of the store counts as empty.
                            if (32'(r_ia) + 32'd1 < DEPTH) begin
                                rd_addr = ADDR_W'(32'(r_ia) + 32'd1);
                                n_state = S_NXT;
                            end
                        end
                    end
                    OP_REMOVE_FRONT: begin
                        n_res = rd_word;
                        n_k   = '0;
                        n_up  = 1'b0;
                        if (rd_word != '0) begin
                            w_en   = 1'b1;
                            w_addr = '0;
                            n_len  = r_len - CNT_W'(1);
                            n_hi   = r_len - CNT_W'(1);
                        end else begin
                            n_st = ST_EMPTY;
                            n_hi = r_len;
                        end
                        n_state = S_MRD;
                    end
                    OP_SWAP: begin
                        n_a     = rd_word;
                        rd_addr = ADDR_W'(r_ib);
                        n_state = S_SWB;
                    end
                    default: begin
                        n_st = ST_DONE;
                    end
                endcase
            end

            S_NXT: begin
                // Close the gap only when the following slot is occupied.
                if (rd_word != '0) begin
                    n_k     = CNT_W'(32'(r_ia));
                    n_hi    = r_len;
                    n_up    = 1'b0;
                    n_state = S_MRD;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_SWB: begin
                if (r_a == '0 || rd_word == '0) begin
                    n_st    = ST_EMPTY;
                    n_state = S_DONE;
                end else begin
                    w_en    = 1'b1;
                    w_addr  = ADDR_W'(r_ia);
                    w_data  = rd_word;
                    n_state = S_SWW;
                end
            end

            S_SWW: begin
                w_en    = 1'b1;
                w_addr  = ADDR_W'(r_ib);
                w_data  = r_a;
                n_state = S_DONE;
            end

            S_MRD: begin
                if (r_up) begin
                    if (r_k != '0) begin
                        rd_addr = ADDR_W'(r_k - CNT_W'(1));
                        n_state = S_MWR;
                    end else begin
                        // Entries shifted up: place the new word at the front.
                        w_en    = 1'b1;
                        w_addr  = '0;
                        w_data  = r_val;
                        n_len   = r_len + CNT_W'(1);
                        n_state = S_DONE;
                    end
                end else begin
                    if (r_k < r_hi) begin
                        n_oob   = (32'(r_k) + 32'd1 >= DEPTH);
                        rd_addr = ADDR_W'(32'(r_k) + 32'd1);
                        n_state = S_MWR;
                    end else begin
                        // Empty the vacated top slot.
                        if (32'(r_hi) < DEPTH) begin
                            w_en   = 1'b1;
                            w_addr = ADDR_W'(r_hi);
                        end
                        n_state = S_DONE;
                    end
                end
            end

            S_MWR: begin
                w_en    = 1'b1;
                w_addr  = ADDR_W'(r_k);
                n_state = S_MRD;
                if (r_up) begin
                    w_data = rd_word;
                    n_k    = r_k - CNT_W'(1);
                end else begin
                    w_data = r_oob ? '0 : rd_word;
                    n_k    = r_k + CNT_W'(1);
                end
            end

            S_DONE: begin
                // Hold until the result register is free or being emptied.
                if (!r_out_vld || i_out_ready) begin
                    n_out.result_value = 32'(r_res);
                    n_out.status       = r_st;
                    n_out.count        = 7'(r_len);
                    n_out_vld          = 1'b1;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_out_vld <= 1'b0;
            r_vld     <= '0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_out_vld <= n_out_vld;
            if (clr) begin
                for (int k = 0; k < DEPTH; k++) begin
                    if (k < int'(r_len)) begin
                        r_vld[k] <= 1'b0;
                    end
                end
            end else if (w_en) begin
                r_vld[w_addr] <= 1'b1;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op  <= i_in_data.op;
            r_ia  <= i_in_data.index;
            r_ib  <= i_in_data.second_index;
            r_val <= WORD_BITS'(i_in_data.value);
        end
        r_k   <= n_k;
        r_hi  <= n_hi;
        r_up  <= n_up;
        r_oob <= n_oob;
        r_a   <= n_a;
        r_res <= n_res;
        r_st  <= n_st;
        r_out <= n_out;
    end

    // Word store: one write, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd_q  <= mem[rd_addr];
        r_rdv_q <= r_vld[rd_addr];
    end

endmodule

// File: hdl/ple_checker.sv
// ============================================================================
// ple_checker - port-level checks for the positional list engine
// Watches the channel handshakes and result fields of the top level.
// ============================================================================
module ple_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input ple_pkg::t_in_item   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ple_pkg::t_out_item  o_out_data
);
    import ple_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // One operation at a time: no transfer in right after one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an operation is in progress");

    // The length never passes the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.count) <= DEPTH)
        else $error("count beyond depth");

    // Refusal for fullness only at full length.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |-> 32'(o_out_data.count) == DEPTH)
        else $error("full status with room left");

    // A failed operation gives back no word.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_DONE |-> o_out_data.result_value == '0)
        else $error("word returned with a failing status");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
